// ----- rtl/core/srq_pkg.sv -----
// Shared types and constants for the sorted priority ready queue.
package srq_pkg;

  localparam int DefQueueDepth = 64;
  localparam int OutCountW     = 7;

  typedef struct packed {
    logic [7:0] pri;
    logic [7:0] id;
  } entry_t;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_ent;
  } cell_ctl_t;

endpackage

// ----- rtl/core/srq_cell.sv -----
// One slot of the sorted shift-register chain.
module srq_cell (
  input  logic               clk,
  input  srq_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  srq_pkg::entry_t    left_ent,
  input  logic               left_le,
  input  srq_pkg::entry_t    right_ent,
  output srq_pkg::entry_t    entry_r,
  output logic               le
);
  import srq_pkg::*;

  entry_t entry_nxt;

  // Empty slots count as "less or equal" so the new entry lands at the tail.
  assign le = !occ || (entry_r.pri <= ctl.new_ent.pri);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.rem) begin
      entry_nxt = right_ent;
    end else if (ctl.ins && le) begin
      entry_nxt = left_le ? left_ent : ctl.new_ent;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- rtl/core/sorted_priority_ready_queue.sv -----
// Top level: sorted priority ready queue built from a chain of slot cells.
//
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low.
//   in_func selects insert (place in_process_id/in_priority_req in priority
//   order, newest first among equals) or remove (pop the head entry).
//   Exactly one result follows per transaction: out_valid is high for one
//   cycle, in the cycle after the accepting edge, carrying out_status,
//   out_removed_id, out_removed_priority and out_entry_count.
//   Throughput is one transaction per cycle while busy is low. Every slot
//   compares against the new priority in parallel and shifts left or right
//   by one in the same edge, so no operation iterates.
//   Insert when full and remove when empty are refused with a status code
//   and leave the queue untouched.
//   Reset (rst_n low, synchronous) empties the queue; busy is set during
//   reset and cleared by its register once rst_n is high. Slot contents are not cleared, only
//   the entry count. The receiver cannot stall: each result must be taken
//   in its strobe cycle.
module sorted_priority_ready_queue #(
  parameter int QUEUE_DEPTH = srq_pkg::DefQueueDepth
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_func,
  input  logic [7:0]                       in_process_id,
  input  logic [7:0]                       in_priority_req,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [7:0]                       out_removed_id,
  output logic [7:0]                       out_removed_priority,
  output logic [srq_pkg::OutCountW-1:0]    out_entry_count
);
  import srq_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count_r, count_nxt;
  logic            busy_r;
  logic            accept, is_insert, is_remove, full, empty;
  cell_ctl_t       ctl;
  status_t         status_nxt;

  entry_t          ent   [QUEUE_DEPTH+1];
  logic            le_w  [QUEUE_DEPTH];
  logic            occ_w [QUEUE_DEPTH];

  logic            out_valid_r;
  status_t         out_status_r;
  logic [7:0]      out_rid_r, out_rpri_r;

  assign busy      = busy_r;
  assign accept    = start && !busy_r;
  assign is_insert = (in_func == FUNC_INSERT);
  assign is_remove = (in_func == FUNC_REMOVE);
  assign full      = (count_r == CntW'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);

  assign ctl.ins         = accept && is_insert && !full;
  assign ctl.rem         = accept && is_remove && !empty;
  assign ctl.new_ent.pri = in_priority_req;
  assign ctl.new_ent.id  = in_process_id;

  // Right neighbor of the last slot; its value never lands in a live slot.
  assign ent[QUEUE_DEPTH] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_ent;
    logic   left_le;
    if (i == 0) begin : g_head
      assign left_ent = '0;
      assign left_le  = 1'b0;
    end else begin : g_body
      assign left_ent = ent[i-1];
      assign left_le  = le_w[i-1];
    end
    assign occ_w[i] = (CntW'(i) < count_r);
    srq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ_w[i]),
      .left_ent  (left_ent),
      .left_le   (left_le),
      .right_ent (ent[i+1]),
      .entry_r   (ent[i]),
      .le        (le_w[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CntW'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_comb begin
    status_nxt = ST_DONE;
    if (is_insert && full) begin
      status_nxt = ST_FULL;
    end else if (is_remove && empty) begin
      status_nxt = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= 1'b0;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_rid_r    <= ctl.rem ? ent[0].id  : 8'd0;
      out_rpri_r   <= ctl.rem ? ent[0].pri : 8'd0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_removed_id       = out_rid_r;
  assign out_removed_priority = out_rpri_r;
  assign out_entry_count      = OutCountW'(count_r);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted transaction without result");

  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (count_r == CntW'(QUEUE_DEPTH)))
    else $error("insert refused while queue not full");

  a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (count_r == '0))
    else $error("remove refused while queue not empty");
`endif

endmodule
